### rtl/core/btk_pkg.sv
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types and constants of the bounded top-k keeper.
// ----------------------------------------------------------------------------
package btk_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int BW_W         = 7;
    localparam logic [BW_W-1:0] BEAM_WIDTH_RST = 7'd64;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic REG_BEAM_WIDTH = 1'b0;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] item_score;
        logic        [31:0] item_tag;
    } t_in_item;

    typedef struct packed {
        logic               out_valid;
        logic signed [31:0] out_score;
        logic        [31:0] out_tag;
        logic               out_last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic ins;
        logic pop;
        logic empty;
    } t_cmd;

    typedef struct packed {
        logic is_drain;
        logic fill_zero;
        logic fill_one;
        logic out_free;
    } t_status;

endpackage

### rtl/core/btk_ctrl.sv
// ----------------------------------------------------------------------------
// btk_ctrl
// Sequencer: accepts commands, runs one insert step, a drain sequence or an empty-store marker.
// ----------------------------------------------------------------------------
module btk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  btk_pkg::t_status i_status,
    output btk_pkg::t_cmd    o_cmd
);
    import btk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INS   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMPTY = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.is_drain) begin
                        n_state = S_INS;
                    end else if (i_status.fill_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_IDLE;
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.fill_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.empty = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> !i_status.fill_zero) else $error("pop from empty store");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !(o_cmd.load)) else $error("two loads in a row");
`endif
endmodule

### rtl/core/btk_dp.sv
// ----------------------------------------------------------------------------
// btk_dp
// Sorted cell row with parallel compare, fill count and output register.
// ----------------------------------------------------------------------------
module btk_dp #(
    parameter int CAPACITY = btk_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  btk_pkg::t_in_item            i_in_item,
    input  logic [btk_pkg::BW_W-1:0]     i_beam_width,
    input  btk_pkg::t_cmd                i_cmd,
    output btk_pkg::t_status             o_status,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output btk_pkg::t_out_item           o_out_item
);
    import btk_pkg::*;

    logic signed [31:0] r_score [CAPACITY];
    logic        [31:0] r_tag   [CAPACITY];
    logic signed [31:0] r_new_score;
    logic        [31:0] r_new_tag;
    logic               r_new_cmd;
    logic [CW-1:0]      r_fill, n_fill;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]       w_eff;
    logic [CW-1:0]       limit;
    logic                grow;
    logic                accept_new;
    logic [CAPACITY-1:0] ge, below_n, stays;

    // effective width: zero acts as one, clipped to the capacity
    always_comb begin
        if (i_beam_width == '0) begin
            w_eff = CW'(1);
        end else if ({1'b0, i_beam_width} > (BW_W+1)'(CAPACITY)) begin
            w_eff = CW'(CAPACITY);
        end else begin
            w_eff = CW'(i_beam_width);
        end
    end

    assign grow  = r_fill < w_eff;
    assign limit = grow ? r_fill + CW'(1) : r_fill;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ge[i]      = r_score[i] >= r_new_score;
            below_n[i] = CW'(i) < r_fill;
            stays[i]   = ge[i] && (CW'(i) < limit - CW'(1));
        end
    end

    // full store: new item wins only if some kept item is strictly lower
    assign accept_new = grow || (|(~ge & below_n));

    assign o_status.is_drain  = (i_in_item.cmd == CMD_DRAIN);
    assign o_status.fill_zero = (r_fill == '0);
    assign o_status.fill_one  = (r_fill == CW'(1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_score <= i_in_item.item_score;
            r_new_tag   <= i_in_item.item_tag;
            r_new_cmd   <= i_in_item.cmd;
        end
        if (i_cmd.ins && accept_new) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if ((CW'(i) < limit) && !stays[i]) begin
                    if (i == 0) begin
                        r_score[i] <= r_new_score;
                        r_tag[i]   <= r_new_tag;
                    end else if (stays[i-1]) begin
                        r_score[i] <= r_new_score;
                        r_tag[i]   <= r_new_tag;
                    end else begin
                        r_score[i] <= r_score[i-1];
                        r_tag[i]   <= r_tag[i-1];
                    end
                end
            end
        end else if (i_cmd.pop) begin
            // drain shifts the row toward the head
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_score[i] <= r_score[i+1];
                r_tag[i]   <= r_tag[i+1];
            end
        end
        if (i_cmd.pop) begin
            r_out.out_valid <= 1'b1;
            r_out.out_score <= r_score[0];
            r_out.out_tag   <= r_tag[0];
            r_out.out_last  <= (r_fill == CW'(1));
        end else if (i_cmd.empty) begin
            r_out <= '{out_valid: 1'b0, out_score: '0, out_tag: '0, out_last: 1'b1};
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.ins && grow) begin
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.pop) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.pop || i_cmd.empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY)) else $error("fill count above capacity");
    a_ins_is_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> (r_new_cmd == CMD_ADD)) else $error("insert on drain item");
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.ins) && (r_fill >= CW'(2)) && (CAPACITY > 1)
        |-> r_score[0] >= r_score[CAPACITY > 1 ? 1 : 0])
        else $error("head pair out of order");
`endif
endmodule

### rtl/core/bounded_top_k_keeper.sv
// ----------------------------------------------------------------------------
// bounded_top_k_keeper
// Keeps the beam_width best scored items; drains them in descending order.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall       | payload
//  in       | i_in_valid  | o_in_stall  | i_in_item  (t_in_item)
//  out      | o_out_valid | i_out_stall | o_out_item (t_out_item)
//  config   | APB write: psel & penable & pwrite, register beam_width at 0
//
// an add is a capture, then one parallel compare-and-shift of the row
// a drain pops its items off the row head, one item per cycle while the output is not stalled
// the output register frees the input side while a result waits
// reset empties the store and sets beam_width to 64; no clearing pass
module bounded_top_k_keeper #(
    parameter int CAPACITY = btk_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  btk_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output btk_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import btk_pkg::*;

    logic [BW_W-1:0] r_beam_width;
    t_cmd            cmd;
    t_status         status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BEAM_WIDTH) ? {{(32-BW_W){1'b0}}, r_beam_width} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_width <= BEAM_WIDTH_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_BEAM_WIDTH)) begin
            r_beam_width <= pwdata[BW_W-1:0];
        end
    end

    btk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    btk_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_item    (i_in_item),
        .i_beam_width (r_beam_width),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule

### bench/tb_bounded_top_k_keeper.sv
// ----------------------------------------------------------------------------
// tb_bounded_top_k_keeper
// Self-checking bench: adds and drains items under random flow control,
// predicts the kept set in a sorted row and checks every drained result.
// ----------------------------------------------------------------------------
module tb_bounded_top_k_keeper;
    timeunit 1ns;
    timeprecision 1ps;
    import btk_pkg::*;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bounded_top_k_keeper uut (.*);

    always #4 i_clk = ~i_clk;

    // predicted store: descending scores, equal scores in insertion order
    logic signed [31:0] row_score [CAP];
    logic        [31:0] row_tag [CAP];
    int                 row_fill;
    int                 width_now;
    t_out_item          drain_q [$];
    int                 errors;
    int                 results_seen;
    int                 items_sent;
    int                 drains_sent;
    int                 cycles;
    int                 stall_mode;

    task automatic row_place(input int limit, input logic signed [31:0] s,
                             input logic [31:0] t);
        int pos;
        pos = 0;
        while (pos + 1 < limit && row_score[pos] >= s) pos++;
        for (int i = limit - 1; i > pos; i--) begin
            row_score[i] = row_score[i-1];
            row_tag[i] = row_tag[i-1];
        end
        row_score[pos] = s;
        row_tag[pos] = t;
    endtask

    task automatic predict_item(input t_in_item it);
        t_out_item r;
        int w;
        if (it.cmd == CMD_ADD) begin
            w = width_now < 1 ? 1 : (width_now > CAP ? CAP : width_now);
            if (row_fill < w) begin
                row_place(row_fill + 1, it.item_score, it.item_tag);
                row_fill++;
            end else if (it.item_score > row_score[row_fill-1]) begin
                row_place(row_fill, it.item_score, it.item_tag);
            end
        end else if (row_fill == 0) begin
            r = '0;
            r.out_last = 1'b1;
            drain_q = {drain_q, r};
        end else begin
            for (int i = 0; i < row_fill; i++) begin
                r.out_valid = 1'b1;
                r.out_score = row_score[i];
                r.out_tag = row_tag[i];
                r.out_last = (i == row_fill - 1);
                drain_q = {drain_q, r};
            end
            row_fill = 0;
        end
    endtask

    // sends one item with a random gap ahead of it; burst keeps valid high
    task automatic send_item(input t_in_item it, input bit no_gap = 0);
        if (!no_gap && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        // stall is settled at the falling edge, so it tells whether the next
        // rising edge takes the item
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        predict_item(it);
        items_sent++;
        if (it.cmd == CMD_DRAIN) drains_sent++;
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (drain_q.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_width(input int w);
        go_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_BEAM_WIDTH);
        pwdata <= 32'(w);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        width_now = w & 7'h7f;
    endtask

    function automatic t_in_item mk(input logic c, input logic [31:0] s,
                                    input logic [31:0] t);
        t_in_item it;
        it.cmd = c;
        it.item_score = s;
        it.item_tag = t;
        return it;
    endfunction

    function automatic logic [31:0] rand_score();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8)) - 4);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 60)) - 30);
        endcase
    endfunction

    task automatic test_directed();
        send_item(mk(CMD_DRAIN, 0, 0));
        send_item(mk(CMD_ADD, 32'h7fffffff, 32'hffffffff));
        send_item(mk(CMD_ADD, 32'h80000000, 32'h00000000));
        send_item(mk(CMD_ADD, 32'h0, 32'h12345678));
        send_item(mk(CMD_ADD, 32'h0, 32'h9abcdef0));
        send_item(mk(CMD_ADD, 32'hffffffff, 32'haaaa5555));
        send_item(mk(CMD_DRAIN, 32'hffffffff, 32'hffffffff));
        send_item(mk(CMD_DRAIN, 0, 0));
    endtask

    task automatic test_narrow_width();
        write_width(3);
        // ties at the lowest, equal-to-lowest dropped, strictly greater replaces
        send_item(mk(CMD_ADD, 5, 1));
        send_item(mk(CMD_ADD, 2, 2));
        send_item(mk(CMD_ADD, 2, 3));
        send_item(mk(CMD_ADD, 2, 4));
        send_item(mk(CMD_ADD, 3, 5));
        send_item(mk(CMD_ADD, 32'h80000000, 6));
        send_item(mk(CMD_DRAIN, 0, 0));
        write_width(0);
        send_item(mk(CMD_ADD, 1, 7));
        send_item(mk(CMD_ADD, 9, 8));
        send_item(mk(CMD_DRAIN, 0, 0));
    endtask

    task automatic test_width_lowered();
        write_width(127);
        for (int i = 0; i < 6; i++) send_item(mk(CMD_ADD, i * 3, 100 + i), 1);
        write_width(2);
        send_item(mk(CMD_ADD, 1, 200));
        send_item(mk(CMD_ADD, 20, 201));
        send_item(mk(CMD_DRAIN, 0, 0));
    endtask

    task automatic test_random(input int n_items, input int w);
        t_in_item it;
        write_width(w);
        for (int k = 0; k < n_items; k++) begin
            it.cmd = ($urandom_range(0, 11) == 0) ? CMD_DRAIN : CMD_ADD;
            it.item_score = rand_score();
            it.item_tag = $urandom();
            send_item(it, $urandom_range(0, 2) != 0);
        end
        send_item(mk(CMD_DRAIN, $urandom(), $urandom()));
    endtask

    task automatic test_full_store();
        write_width(64);
        for (int i = 0; i < 70; i++) send_item(mk(CMD_ADD, rand_score(), $urandom()), 1);
        send_item(mk(CMD_DRAIN, 0, 0));
    endtask

    // receiver stall pattern, changes mode every so often
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (drain_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_out_item);
                errors++;
            end else begin
                want = drain_q.pop_front();
                if (want.out_valid !== o_out_item.out_valid) begin
                    $display("%0t: out_valid exp %0b got %0b", $realtime,
                             want.out_valid, o_out_item.out_valid);
                    errors++;
                end
                if (want.out_score !== o_out_item.out_score) begin
                    $display("%0t: out_score exp %0d got %0d", $realtime,
                             want.out_score, o_out_item.out_score);
                    errors++;
                end
                if (want.out_tag !== o_out_item.out_tag) begin
                    $display("%0t: out_tag exp %h got %h", $realtime,
                             want.out_tag, o_out_item.out_tag);
                    errors++;
                end
                if (want.out_last !== o_out_item.out_last) begin
                    $display("%0t: out_last exp %0b got %0b", $realtime,
                             want.out_last, o_out_item.out_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        drains_sent = 0;
        cycles = 0;
        stall_mode = 0;
        row_fill = 0;
        width_now = 64;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_narrow_width();
        test_width_lowered();
        test_full_store();
        test_random(50, 5);
        test_random(40, 1);
        test_random(60, 64);
        go_idle();
        repeat (80) @(negedge i_clk);
        if (drain_q.size() != 0) begin
            $display("%0d expected results never arrived", drain_q.size());
            errors++;
        end
        $display("sent %0d items (%0d drains), checked %0d results", items_sent,
                 drains_sent, results_seen);
        $display("widths 0..127 incl. lowering while filled, ties and extremes");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
